// ===== sv/wpm_pkg.sv =====
// Shared types, constants and helpers for the wildcard pattern matcher.
// No dependencies; used by wpm_cell and wildcard_pattern_matcher.
package wpm_pkg;

	// Largest pattern the row of cells can hold by default
	localparam int PATTERN_MAX_DEF = 16;

	// Width of the pattern length register
	localparam int LEN_W = 5;

	// Width of a configuration word and of the register index
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	// Pattern metacharacters
	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE  = 8'h3F;

	// ASCII letter bounds and case offset
	localparam logic [7:0] UPPER_A    = 8'h41;
	localparam logic [7:0] UPPER_Z    = 8'h5A;
	localparam logic [7:0] CASE_SHIFT = 8'h20;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_PATTERN_LEN  = 3'd2,
		REG_IGNORE_CASE  = 3'd3
	} wpm_reg_t;

	// Signals one cell hands to the next
	typedef struct packed {
		logic carry_cur;  // star closure ripple over the held positions
		logic carry_nxt;  // star closure ripple over the advanced positions
		logic step;       // position i+1 reached by consuming one byte
	} wpm_link_t;

	// Fold an ASCII capital to lower case when case is ignored
	function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
		logic [7:0] r;
		r = c;
		if (ic && (c >= UPPER_A) && (c <= UPPER_Z)) begin
			r = c + CASE_SHIFT;
		end
		return r;
	endfunction

endpackage

// ===== sv/wpm_cell.sv =====
// One pattern position of the matcher: holds its live bit and passes star
// closure and byte steps to the next position. Depends on wpm_pkg.
module wpm_cell #(
	parameter logic START = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        pat_byte,
	input  logic              ignore_case,
	input  logic              en,        // this position is below the length
	input  logic              keep,      // this position is within the length
	input  logic [7:0]        text_byte,
	input  logic              advance,
	input  logic              restart,
	input  wpm_pkg::wpm_link_t link_in,
	output wpm_pkg::wpm_link_t link_out,
	output logic              closed_cur,
	output logic              closed_nxt,
	output logic              live
);

	logic live_q;
	logic is_star;
	logic is_any;
	logic hit;
	logic stay;

	// Decode the pattern byte and compare with the text byte
	assign is_star = (pat_byte == wpm_pkg::STAR_BYTE);
	assign is_any  = (pat_byte == wpm_pkg::ANY_BYTE);
	assign hit     = is_any ||
		(wpm_pkg::fold(pat_byte, ignore_case) == wpm_pkg::fold(text_byte, ignore_case));

	// Close the held set over stars
	assign closed_cur         = (live_q & keep) | link_in.carry_cur;
	assign link_out.carry_cur = closed_cur & is_star & en;

	// A star keeps its position, any other match steps forward
	assign stay          = link_out.carry_cur;
	assign link_out.step = closed_cur & en & ~is_star & hit;

	// Close the advanced set over stars
	assign closed_nxt         = stay | link_in.step | link_in.carry_nxt;
	assign link_out.carry_nxt = closed_nxt & is_star & en;

	assign live = live_q;

	// Hold, advance or restart the live bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= START;
		end else if (restart) begin
			live_q <= START;
		end else if (advance) begin
			live_q <= closed_nxt;
		end
	end

endmodule

// ===== sv/wildcard_pattern_matcher.sv =====
// Top level of the wildcard pattern matcher: configuration registers, the
// row of position cells, end position and result register. Depends on
// wpm_pkg and wpm_cell.

// The block takes one text item in every cycle unless the text channel
// stalls, and gives the matched bit in the cycle after the item marked last
// is accepted. The live pattern positions sit in a row of PATTERN_MAX cells
// plus one end position; for each byte the held set is closed over stars,
// stepped by the byte and closed again, both closures rippling across the
// cell row within the cycle. A single result register sits on the output;
// the text channel stalls only while a result is held and not taken in that
// cycle. '*' matches any run of bytes, '?' any one byte; lengths above
// PATTERN_MAX are clipped and an empty pattern matches every string.
module wildcard_pattern_matcher #(
	parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wpm_pkg::CFG_DATA_W-1:0] cfg_data,
	// text channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     text_byte,
	input  logic                           has_byte,
	input  logic                           last,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           matched
);

	localparam int N = PATTERN_MAX;
	localparam int LW = wpm_pkg::LEN_W;

	logic [wpm_pkg::CFG_DATA_W-1:0] pat_low_q;
	logic [wpm_pkg::CFG_DATA_W-1:0] pat_high_q;
	logic [LW-1:0]                  len_q;
	logic                           ignore_case_q;
	logic [LW-1:0]                  used_len;
	logic                           in_fire;
	logic                           advance;
	logic                           restart;
	wpm_pkg::wpm_link_t             link [0:N];
	logic [N:0]                     closed_cur;
	logic [N:0]                     closed_nxt;
	logic [N:0]                     live_vec;
	logic                           live_end_q;
	logic                           match_sel;
	logic                           out_valid_q;
	logic                           matched_q;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q     <= '0;
			pat_high_q    <= '0;
			len_q         <= '0;
			ignore_case_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wpm_pkg::REG_PATTERN_LOW:  pat_low_q     <= cfg_data;
				wpm_pkg::REG_PATTERN_HIGH: pat_high_q    <= cfg_data;
				wpm_pkg::REG_PATTERN_LEN:  len_q         <= cfg_data[LW-1:0];
				wpm_pkg::REG_IGNORE_CASE:  ignore_case_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clip the length to the row of cells
	assign used_len = (len_q > LW'(N)) ? LW'(N) : len_q;

	// Handshake
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign advance  = in_fire && has_byte;
	assign restart  = in_fire && last;

	assign link[0] = '0;

	// Row of position cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [7:0] pbyte;
		if (i < 8) begin : g_low
			assign pbyte = pat_low_q[i*8 +: 8];
		end else begin : g_high
			assign pbyte = pat_high_q[(i-8)*8 +: 8];
		end

		wpm_cell #(
			.START((i == 0) ? 1'b1 : 1'b0)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.pat_byte   (pbyte),
			.ignore_case(ignore_case_q),
			.en         (used_len > LW'(i)),
			.keep       (used_len >= LW'(i)),
			.text_byte  (text_byte),
			.advance    (advance),
			.restart    (restart),
			.link_in    (link[i]),
			.link_out   (link[i+1]),
			.closed_cur (closed_cur[i]),
			.closed_nxt (closed_nxt[i]),
			.live       (live_vec[i])
		);
	end

	// End position: reached by stepping past the last pattern byte or over a final star
	assign closed_cur[N] = (live_end_q && (used_len == LW'(N))) || link[N].carry_cur;
	assign closed_nxt[N] = link[N].step || link[N].carry_nxt;
	assign live_vec[N]   = live_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_end_q <= 1'b0;
		end else if (restart) begin
			live_end_q <= 1'b0;
		end else if (advance) begin
			live_end_q <= closed_nxt[N];
		end
	end

	// Pick the position at the pattern length
	always_comb begin
		match_sel = 1'b0;
		for (int k = 0; k <= N; k++) begin
			if (used_len == LW'(k)) begin
				match_sel = has_byte ? closed_nxt[k] : closed_cur[k];
			end
		end
		if (used_len == '0) begin
			match_sel = 1'b1;
		end
	end

	// Result register: load on the last item, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			matched_q   <= 1'b0;
		end else if (restart) begin
			out_valid_q <= 1'b1;
			matched_q   <= match_sel;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

	// An empty pattern always gives a match
	a_empty_match: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last && (used_len == '0) |=> out_valid && matched)
		else $error("empty pattern did not match");

	// The end of a string leaves only the start position live
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last |=> live_vec == (N+1)'(1))
		else $error("live set not restarted after last item");

	// An empty result register never stalls the text channel
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no result pending");

	// A pending result that is not taken keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(matched))
		else $error("pending result changed");

endmodule
